// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define DQ_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("dq assertion failed");

// consequent holds in the same cycle as the antecedent
`define DQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dq assertion failed");

// consequent holds in the cycle after the antecedent
`define DQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dq assertion failed");

`endif

// ===== sv/dq_pkg.sv =====
package dq_pkg;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_LIST       = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int CQ_AW    = 1;
   localparam int CQ_DEPTH = 2 ** CQ_AW;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT,
      CMD_PUSH_BACK,
      CMD_POP_FRONT,
      CMD_POP_BACK,
      CMD_LIST
   } dq_cmd_kind_type;

   typedef struct packed {
      dq_cmd_kind_type    kind;
      logic signed [31:0] value;
   } dq_cmd_type;

   typedef struct packed {
      logic       push;
      dq_cmd_type cmd;
   } dq_enq_type;

   typedef struct packed {
      logic       valid;
      dq_cmd_type cmd;
   } dq_deq_type;

   typedef enum logic {
      BK_IDLE,
      BK_LIST
   } dq_back_state_type;

endpackage

// ===== sv/dq_front.sv =====
module dq_front (
   input  logic               start,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic               queue_full,
   output logic               busy,
   output dq_pkg::dq_enq_type enq
);
   import dq_pkg::*;

   logic accept;

   assign busy   = queue_full;
   assign accept = start && !queue_full;

   always_comb begin
      enq.cmd.value = req_value;
      enq.cmd.kind  = CMD_PUSH_FRONT;
      enq.push      = 1'b0;
      unique case (req_opcode)
         OP_PUSH_FRONT: begin
            enq.cmd.kind = CMD_PUSH_FRONT;
            enq.push     = accept;
         end
         OP_PUSH_BACK: begin
            enq.cmd.kind = CMD_PUSH_BACK;
            enq.push     = accept;
         end
         OP_POP_FRONT: begin
            enq.cmd.kind = CMD_POP_FRONT;
            enq.push     = accept;
         end
         OP_POP_BACK: begin
            enq.cmd.kind = CMD_POP_BACK;
            enq.push     = accept;
         end
         OP_LIST: begin
            enq.cmd.kind = CMD_LIST;
            enq.push     = accept;
         end
         // undefined opcodes are taken and dropped
         default: begin
            enq.push = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/dq_cmd_queue.sv =====
`include "assert_macros.svh"

module dq_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  dq_pkg::dq_enq_type enq,
   input  logic               pop,
   output logic               full,
   output dq_pkg::dq_deq_type deq
);
   import dq_pkg::*;

   dq_cmd_type         entries_ff [CQ_DEPTH];
   logic [CQ_AW-1:0]   wr_ptr_ff;
   logic [CQ_AW-1:0]   rd_ptr_ff;
   logic [CQ_AW:0]     count_ff;
   logic [CQ_AW-1:0]   wr_ptr_in;
   logic [CQ_AW-1:0]   rd_ptr_in;
   logic [CQ_AW:0]     count_in;
   logic               do_pop;

   assign full      = count_ff == (CQ_AW + 1)'(CQ_DEPTH);
   assign deq.valid = count_ff != '0;
   assign deq.cmd   = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && deq.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq.push) begin
         wr_ptr_in = wr_ptr_ff + CQ_AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + CQ_AW'(1);
      end
      if (enq.push && !do_pop) begin
         count_in = count_ff + (CQ_AW + 1)'(1);
      end else if (do_pop && !enq.push) begin
         count_in = count_ff - (CQ_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq.push) begin
         entries_ff[wr_ptr_ff] <= enq.cmd;
      end
   end

   `DQ_ASSERT_ALWAYS(a_cq_count_bound, clock, reset, count_ff <= (CQ_AW + 1)'(CQ_DEPTH))
   `DQ_ASSERT_IMPL(a_cq_no_overrun, clock, reset, enq.push, !full || do_pop)
   `DQ_ASSERT_IMPL(a_cq_pop_valid, clock, reset, pop, deq.valid)

endmodule

// ===== sv/dq_back.sv =====
`include "assert_macros.svh"

module dq_back #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  dq_pkg::dq_deq_type deq,
   output logic               pop,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_value_out,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_of_run
);
   import dq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
   localparam logic [IW-1:0] LAST_POS = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a,
                                              input logic [IW-1:0] b);
      logic [IW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[IW-1:0];
   endfunction

   logic signed [31:0] entry_store_ff [DEPTH];
   logic signed [31:0] rd_data_ff;

   dq_back_state_type  state_ff, state_in;
   logic [IW-1:0]      front_ff, front_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;

   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_status_ff, out_status_in;
   logic               out_last_ff, out_last_in;
   logic               out_mem_ff, out_mem_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic               is_full;
   logic               is_empty;
   logic [CW-1:0]      count_dec;
   logic               list_last;

   assign is_full   = count_ff == FULL_CNT;
   assign is_empty  = count_ff == '0;
   assign count_dec = count_ff - CW'(1);
   assign list_last = (CW'(idx_ff) + CW'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      out_valid_in  = 1'b0;
      out_status_in = ST_OK;
      out_last_in   = 1'b1;
      out_mem_in    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (deq.valid) begin
               pop          = 1'b1;
               out_valid_in = 1'b1;
               unique case (deq.cmd.kind)
                  CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        out_status_in = ST_FULL;
                     end else begin
                        front_in = (front_ff == '0) ? LAST_POS : front_ff - IW'(1);
                        wr_en    = 1'b1;
                        wr_addr  = front_in;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (is_full) begin
                        out_status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = ring_add(front_ff, count_ff[IW-1:0]);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (is_empty) begin
                        out_status_in = ST_EMPTY;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = front_ff;
                        front_in   = ring_add(front_ff, IW'(1));
                        count_in   = count_dec;
                        out_mem_in = 1'b1;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (is_empty) begin
                        out_status_in = ST_EMPTY;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = ring_add(front_ff, count_dec[IW-1:0]);
                        count_in   = count_dec;
                        out_mem_in = 1'b1;
                     end
                  end
                  CMD_LIST: begin
                     if (is_empty) begin
                        out_status_in = ST_EMPTY;
                     end else begin
                        rd_en       = 1'b1;
                        rd_addr     = front_ff;
                        out_mem_in  = 1'b1;
                        out_last_in = count_ff == CW'(1);
                        if (count_ff != CW'(1)) begin
                           idx_in   = IW'(1);
                           state_in = BK_LIST;
                        end
                     end
                  end
                  default: begin
                     out_valid_in = 1'b0;
                  end
               endcase
            end
         end
         BK_LIST: begin
            rd_en        = 1'b1;
            rd_addr      = ring_add(front_ff, idx_ff);
            out_valid_in = 1'b1;
            out_mem_in   = 1'b1;
            out_last_in  = list_last;
            idx_in       = idx_ff + IW'(1);
            if (list_last) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      out_mem_ff    <= out_mem_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= deq.cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_store_ff[rd_addr];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_value_out   = out_mem_ff ? rd_data_ff : '0;

   `DQ_ASSERT_ALWAYS(a_bk_count_bound, clock, reset, count_ff <= FULL_CNT)
   `DQ_ASSERT_IMPL(a_bk_list_index, clock, reset, state_ff == BK_LIST, CW'(idx_ff) < count_ff)
   `DQ_ASSERT_IMPL(a_bk_error_final, clock, reset, out_valid_ff && out_status_ff != ST_OK, out_last_ff && !out_mem_ff)
   `DQ_ASSERT_NEXT(a_bk_list_holds_count, clock, reset, state_ff == BK_LIST, $stable(count_ff) || state_ff == BK_IDLE)

endmodule

// ===== sv/double_ended_queue_top.sv =====
// double-ended queue of signed 32-bit values held in a ring store of DEPTH words
// request channel: req_opcode and req_value are taken at a clock edge where start
//   is high and busy is low; opcodes push front, push back, pop front, pop back
//   and list; undefined opcodes are taken and dropped with no result
// response channel: rsp_valid marks one result for exactly one cycle with
//   rsp_value_out, rsp_status and rsp_last_of_run; the receiver cannot stall it
// a front decoder feeds a two-entry command queue, and the back end owns the
//   ring store, front pointer and entry count
// path: with the back end idle, a push or pop goes through a command queue entry,
//   then the back end output registers; a running list delays later transactions
// throughput: one push or pop per cycle while no list holds the back end; a list
//   reads out the stored entries one at a time through the single read port of
//   the ring store; busy rises only while the command queue is full
// each defined opcode yields exactly one result, but a list of a non-empty queue
//   yields one per entry front first, the last flagged by rsp_last_of_run
// reset empties the queue and drops pending transactions; the ring store is not
//   cleared since only written entries are ever read
module double_ended_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_value_out,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_of_run
);
   import dq_pkg::*;

   dq_enq_type enq;
   dq_deq_type deq;
   logic       queue_full;
   logic       deq_pop;

   dq_front u_front (
      .start      (start),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .queue_full (queue_full),
      .busy       (busy),
      .enq        (enq)
   );

   dq_cmd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .enq   (enq),
      .pop   (deq_pop),
      .full  (queue_full),
      .deq   (deq)
   );

   dq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .deq             (deq),
      .pop             (deq_pop),
      .rsp_valid       (rsp_valid),
      .rsp_value_out   (rsp_value_out),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
